@@ hw/rtl/hms_pkg.sv @@
// hms_pkg: shared types and constants for the H.M.S time text parser.
// No dependencies; imported by the parser modules.
`timescale 1ns / 1ps
`default_nettype none
package hms_pkg;

  localparam int unsigned FIELD_W = 31;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned HMUL_W  = 12;
  localparam int unsigned MMUL_W  = 6;

  localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};
  localparam logic [HMUL_W-1:0]  SEC_PER_HOUR = 12'd3600;
  localparam logic [MMUL_W-1:0]  SEC_PER_MIN  = 6'd60;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;

  // Fields and syntax verdict of one finished text.
  typedef struct packed {
    logic [FIELD_W-1:0] hours;
    logic [FIELD_W-1:0] minutes;
    logic [FIELD_W-1:0] seconds;
    logic               syntax_ok;
  } hms_fin_t;

endpackage
`default_nettype wire

@@ hw/rtl/hms_if.sv @@
// hms_if: valid/ready channel interfaces for input bytes and results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface hms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface hms_out_if;
  logic        valid;
  logic        ready;
  logic        parse_ok;
  logic [31:0] total_seconds;

  modport source (output valid, output parse_ok, output total_seconds, input ready);
  modport sink   (input valid, input parse_ok, input total_seconds, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hms_scan.sv @@
// hms_scan: input register and per-byte scanner state; emits field values
// and syntax verdict on the last byte. Depends on hms_pkg, hms_if.
`timescale 1ns / 1ps
`default_nettype none
module hms_scan
  import hms_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  hms_in_if.sink     in_ch,
  output hms_fin_t   fin,
  output logic       fin_valid,
  input  wire logic  fin_ready
);

  typedef enum logic [1:0] {PH_BEFORE, PH_TEXT, PH_TRAIL} phase_t;

  function automatic logic [FIELD_W-1:0] add_digit(input logic [FIELD_W-1:0] acc,
                                                   input logic [3:0] d);
    logic [FIELD_W+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{FIELD_W{1'b0}}, d};
    add_digit = (v > {4'b0000, FIELD_MAX}) ? FIELD_MAX : v[FIELD_W-1:0];
  endfunction

  // input register
  logic       s0_v_r;
  logic [7:0] s0_byte_r;
  logic       s0_last_r;

  // scanner state
  phase_t             phase_r, phase_nxt;
  logic [FIELD_W-1:0] hours_r, hours_nxt;
  logic [FIELD_W-1:0] minutes_r, minutes_nxt;
  logic [FIELD_W-1:0] seconds_r, seconds_nxt;
  logic [1:0]         dots_r, dots_nxt;
  logic               min_seen_r, min_seen_nxt;
  logic               last_dot_r, last_dot_nxt;
  logic               broken_r, broken_nxt;

  hms_fin_t fin_r, fin_nxt;
  logic     fin_v_r;

  logic s1_free;
  logic s0_fire;

  assign s1_free     = !fin_v_r || fin_ready;
  assign s0_fire     = s0_v_r && (!s0_last_r || s1_free);
  assign in_ch.ready = !s0_v_r || s0_fire;
  assign fin         = fin_r;
  assign fin_valid   = fin_v_r;

  always_comb begin
    phase_nxt    = phase_r;
    hours_nxt    = hours_r;
    minutes_nxt  = minutes_r;
    seconds_nxt  = seconds_r;
    dots_nxt     = dots_r;
    min_seen_nxt = min_seen_r;
    last_dot_nxt = last_dot_r;
    broken_nxt   = broken_r;
    if (s0_byte_r inside {CH_SP, [CH_TAB:CH_CR]}) begin
      if (phase_r == PH_TEXT) begin
        phase_nxt = PH_TRAIL;
      end
    end else begin
      // non-blank after trailing whitespace means inner whitespace
      if (phase_r == PH_TRAIL) begin
        broken_nxt = 1'b1;
      end
      if (s0_byte_r == CH_DOT) begin
        if (phase_r == PH_BEFORE) begin
          broken_nxt = 1'b1;
        end
        if (dots_r != 2'd3) begin
          dots_nxt = dots_r + 2'd1;
        end
        seconds_nxt  = '0;
        last_dot_nxt = 1'b1;
      end else if (s0_byte_r inside {[CH_0:CH_9]}) begin
        case (dots_r)
          2'd0: hours_nxt = add_digit(hours_r, s0_byte_r[3:0]);
          2'd1: begin
            minutes_nxt  = add_digit(minutes_r, s0_byte_r[3:0]);
            min_seen_nxt = 1'b1;
          end
          default: seconds_nxt = add_digit(seconds_r, s0_byte_r[3:0]);
        endcase
        last_dot_nxt = 1'b0;
      end else begin
        broken_nxt = 1'b1;
      end
      if (phase_r == PH_BEFORE) begin
        phase_nxt = PH_TEXT;
      end
    end
  end

  always_comb begin
    fin_nxt.hours     = hours_nxt;
    fin_nxt.minutes   = minutes_nxt;
    fin_nxt.seconds   = seconds_nxt;
    fin_nxt.syntax_ok = !broken_nxt && (phase_nxt != PH_BEFORE) && dots_nxt[1]
                        && !last_dot_nxt && ((dots_nxt == 2'd3) || min_seen_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r     <= 1'b0;
      fin_v_r    <= 1'b0;
      phase_r    <= PH_BEFORE;
      hours_r    <= '0;
      minutes_r  <= '0;
      seconds_r  <= '0;
      dots_r     <= '0;
      min_seen_r <= 1'b0;
      last_dot_r <= 1'b0;
      broken_r   <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s0_v_r    <= 1'b1;
        s0_byte_r <= in_ch.text_byte;
        s0_last_r <= in_ch.is_last;
      end else if (s0_fire) begin
        s0_v_r <= 1'b0;
      end

      if (s0_fire && s0_last_r) begin
        // text done: hand off and start over
        fin_v_r    <= 1'b1;
        fin_r      <= fin_nxt;
        phase_r    <= PH_BEFORE;
        hours_r    <= '0;
        minutes_r  <= '0;
        seconds_r  <= '0;
        dots_r     <= '0;
        min_seen_r <= 1'b0;
        last_dot_r <= 1'b0;
        broken_r   <= 1'b0;
      end else begin
        if (fin_ready) begin
          fin_v_r <= 1'b0;
        end
        if (s0_fire) begin
          phase_r    <= phase_nxt;
          hours_r    <= hours_nxt;
          minutes_r  <= minutes_nxt;
          seconds_r  <= seconds_nxt;
          dots_r     <= dots_nxt;
          min_seen_r <= min_seen_nxt;
          last_dot_r <= last_dot_nxt;
          broken_r   <= broken_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hms_total.sv @@
// hms_total: product stage and result register for the seconds total.
// Depends on hms_pkg, hms_if.
`timescale 1ns / 1ps
`default_nettype none
module hms_total
  import hms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hms_fin_t  fin,
  input  wire logic      fin_valid,
  output logic           fin_ready,
  hms_out_if.source      out_ch
);

  localparam int unsigned HP_W  = FIELD_W + HMUL_W;
  localparam int unsigned MP_W  = FIELD_W + MMUL_W;
  localparam int unsigned SUM_W = HP_W + 1;

  logic                  s2_v_r;
  logic [HP_W-1:0]       hp_r;
  logic [MP_W-1:0]       mp_r;
  logic [FIELD_W-1:0]    sec_r;
  logic                  syn_ok_r;

  logic                  out_v_r;
  logic                  ok_r;
  logic [TOTAL_W-1:0]    total_r;

  logic                  out_free;
  logic [SUM_W-1:0]      sum;
  logic                  sum_ok;

  assign out_free  = !out_v_r || out_ch.ready;
  assign fin_ready = !s2_v_r || out_free;

  assign sum = {1'b0, hp_r} + {{(SUM_W-MP_W){1'b0}}, mp_r}
               + {{(SUM_W-FIELD_W){1'b0}}, sec_r};
  // total must fit in 32 bits
  assign sum_ok = syn_ok_r && (sum[SUM_W-1:TOTAL_W] == '0);

  assign out_ch.valid         = out_v_r;
  assign out_ch.parse_ok      = ok_r;
  assign out_ch.total_seconds = total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (fin_valid && fin_ready) begin
        s2_v_r   <= 1'b1;
        hp_r     <= {{HMUL_W{1'b0}}, fin.hours} * {{FIELD_W{1'b0}}, SEC_PER_HOUR};
        mp_r     <= {{MMUL_W{1'b0}}, fin.minutes} * {{FIELD_W{1'b0}}, SEC_PER_MIN};
        sec_r    <= fin.seconds;
        syn_ok_r <= fin.syntax_ok;
      end else if (out_free) begin
        s2_v_r <= 1'b0;
      end

      if (s2_v_r && out_free) begin
        out_v_r <= 1'b1;
        ok_r    <= sum_ok;
        total_r <= sum_ok ? sum[TOTAL_W-1:0] : '0;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hms_time_string_parser_core.sv @@
// H.M.S time text parser, top level. Depends on hms_pkg, hms_if, hms_scan, hms_total.
// Throughput: one byte per cycle, sustained, while the result side takes items.
// A last byte reaches the result through the input register, the scanner hand-off
//   register, the product register and the result register; each can stall.
// Reset (rst_n low, synchronous) empties all stages and clears the scanner state.
`timescale 1ns / 1ps
`default_nettype none
module hms_time_string_parser_core
  import hms_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  hms_in_if.sink     in_ch,
  hms_out_if.source  out_ch
);

  hms_fin_t fin;
  logic     fin_valid;
  logic     fin_ready;

  hms_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fin       (fin),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready)
  );

  hms_total u_total (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin       (fin),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
